FILE: src/rgblab_pkg.sv
// Shared types, constants and the sRGB linearization table for the
// RGB to CIELAB color difference pipeline. No dependencies.
package rgblab_pkg;

  localparam int Q_FRAC     = 24;
  localparam int DIST_FRAC  = 16;
  localparam int LIN_W      = 25;
  localparam int NUM_W      = 41;
  localparam int LAB_W      = 36;
  localparam int LABF_NUM_W = 31;
  localparam int L_W        = 15;
  localparam int AB_W       = 16;
  localparam int DIST_W     = 17;

  localparam int CBRT_STEPS = 25;
  localparam int SQRT_STEPS = 28;
  localparam int CDIV_LAT   = 4;
  localparam int LABF_LAT   = 2 * CBRT_STEPS;
  localparam int LANE_LAT   = 3 + CDIV_LAT + LABF_LAT + 1;
  localparam int MERGE_LAT  = 5 + SQRT_STEPS + 1;
  localparam int TOTAL_LAT  = LANE_LAT + MERGE_LAT;

  typedef logic [LIN_W-1:0] lin_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef logic signed [LAB_W-1:0] labv_t;
  typedef lin_t lin_table_t [256];

  typedef struct packed {
    labv_t lightness;
    labv_t green_red;
    labv_t blue_yellow;
  } lab_t;

  localparam num_t COEF_XR = 41'd41240;
  localparam num_t COEF_XG = 41'd35760;
  localparam num_t COEF_XB = 41'd18050;
  localparam num_t COEF_YR = 41'd2126;
  localparam num_t COEF_YG = 41'd7152;
  localparam num_t COEF_YB = 41'd722;
  localparam num_t COEF_ZR = 41'd1930;
  localparam num_t COEF_ZG = 41'd11920;
  localparam num_t COEF_ZB = 41'd95050;
  localparam num_t RND_X   = 41'd47523;
  localparam num_t RND_Y   = 41'd5000;
  localparam num_t RND_Z   = 41'd54441;

  localparam longint unsigned DIV_X    = 64'd95047;
  localparam longint unsigned DIV_Y    = 64'd10000;
  localparam longint unsigned DIV_Z    = 64'd108883;
  localparam longint unsigned DIV_LABF = 64'd1000;

  localparam lin_t LABF_THRESH = LIN_W'((64'd8856 << Q_FRAC) / 64'd1000000);
  localparam lin_t LABF_OFS    = LIN_W'(((64'd4 << Q_FRAC) + 64'd14) / 64'd29);

  localparam labv_t LAB_C_L = 36'sd116;
  localparam labv_t LAB_C_A = 36'sd500;
  localparam labv_t LAB_C_B = 36'sd200;
  localparam labv_t L_OFS   = LAB_W'(64'd16 << Q_FRAC);

  localparam logic [L_W-1:0]    L_MAX    = '1;
  localparam logic [AB_W-1:0]   AB_MAX   = 16'h7fff;
  localparam logic [AB_W-1:0]   AB_MIN   = 16'h8000;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  function automatic lin_table_t build_lin_table();
    lin_table_t tbl;
    longint unsigned cc, t, s, lo, hi, mid, p, lin30;
    for (int c = 0; c < 256; c++) begin
      cc = longint'(c);
      if (cc * 64'd100000 <= 64'd255 * 64'd4045) begin
        tbl[c] = LIN_W'((cc * 64'd1677721600 + 64'd164730) / 64'd329460);
      end else begin
        t = ((((64'd1000 * cc) + 64'd14025) << 30) + 64'd134512) / 64'd269025;
        s = (t * t + (64'd1 << 29)) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          p = mid;
          for (int k = 0; k < 4; k++) p = (p * mid) >> 30;
          if (p <= s) lo = mid;
          else hi = mid - 64'd1;
        end
        lin30 = (s * lo + (64'd1 << 29)) >> 30;
        tbl[c] = LIN_W'((lin30 + 64'd32) >> 6);
      end
    end
    return tbl;
  endfunction

  localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

FILE: src/rgblab_cdiv.sv
// Pipelined division by a constant: reciprocal multiply plus one correction step.
// Depends on nothing.
module rgblab_cdiv #(
  parameter int              NW      = 41,
  parameter longint unsigned DIVISOR = 95047
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  output logic [NW-1:0] quo
);
  localparam longint unsigned MUL = (64'd1 << NW) / DIVISOR;
  localparam int MW = $clog2(MUL + 1);
  localparam int DW = $clog2(DIVISOR + 1);
  localparam int QW = NW - $clog2(DIVISOR) + 1;
  localparam int LW = (NW + 1) / 2;
  localparam int HW = NW - LW;
  localparam logic [MW-1:0] MUL_C = MW'(MUL);
  localparam logic [DW-1:0] DIV_C = DW'(DIVISOR);

  logic [LW+MW-1:0] prod_lo;
  logic [HW+MW-1:0] prod_hi;
  logic [NW+MW-1:0] prod;
  logic [NW-1:0]    num1, num2, num3, rem;
  logic [QW-1:0]    q2, q3, q4;
  logic [QW+DW-1:0] back3;

  assign prod = {prod_hi, {LW{1'b0}}} + (NW+MW)'(prod_lo);
  assign rem  = num3 - back3[NW-1:0];
  assign quo  = NW'(q4);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_lo <= num[LW-1:0] * MUL_C;
      prod_hi <= num[NW-1:LW] * MUL_C;
      num1    <= num;
      q2      <= prod[NW+QW-1:NW];
      num2    <= num1;
      back3   <= q2 * DIV_C;
      q3      <= q2;
      num3    <= num2;
      q4      <= (rem >= NW'(DIVISOR)) ? q3 + 1'b1 : q3;
    end
  end

endmodule

FILE: src/rgblab_labf.sv
// CIELAB companding function f(v) in Q1.24: bit-serial cube root pipeline
// with the linear segment alongside. Depends on rgblab_pkg and rgblab_cdiv.
module rgblab_labf (
  input  logic             clk,
  input  logic             en,
  input  rgblab_pkg::lin_t v,
  output rgblab_pkg::lin_t f
);
  import rgblab_pkg::*;

  localparam int SQ_W    = 2 * LIN_W;
  localparam int CUBE_W  = SQ_W - Q_FRAC + LIN_W;
  localparam int LIN_DLY = LABF_LAT - CDIV_LAT - 1;

  lin_t v_a [CBRT_STEPS];
  lin_t r_a [CBRT_STEPS];
  lin_t lin_d [LIN_DLY];
  logic sel_d [LABF_LAT];
  logic [LABF_NUM_W-1:0] lnum, lquo;

  for (genvar i = 0; i < CBRT_STEPS; i++) begin : g_step
    localparam lin_t BIT = lin_t'(1) << (CBRT_STEPS - 1 - i);
    lin_t v_in, r_in, trial_q, v_q, r_q;
    logic [SQ_W-1:0]   sq_q;
    logic [CUBE_W-1:0] cube;
    if (i == 0) begin : g_first
      assign v_in = v;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_a[i-1];
      assign r_in = r_a[i-1];
    end
    assign cube = sq_q[SQ_W-1:Q_FRAC] * trial_q;
    always_ff @(posedge clk) begin
      if (en) begin
        trial_q <= r_in | BIT;
        sq_q    <= (r_in | BIT) * (r_in | BIT);
        v_q     <= v_in;
        r_q     <= r_in;
        v_a[i]  <= v_q;
        r_a[i]  <= (cube[CUBE_W-1:Q_FRAC] <= (CUBE_W-Q_FRAC)'(v_q)) ? trial_q : r_q;
      end
    end
  end

  // linear segment only matters below the threshold, which fits in 18 bits
  rgblab_cdiv #(.NW(LABF_NUM_W), .DIVISOR(DIV_LABF)) u_div (
    .clk (clk),
    .en  (en),
    .num (lnum),
    .quo (lquo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      lnum     <= LABF_NUM_W'(v[17:0]) * 31'd7787 + 31'd500;
      lin_d[0] <= lquo[LIN_W-1:0] + LABF_OFS;
      for (int k = 1; k < LIN_DLY; k++) lin_d[k] <= lin_d[k-1];
      sel_d[0] <= v > LABF_THRESH;
      for (int k = 1; k < LABF_LAT; k++) sel_d[k] <= sel_d[k-1];
    end
  end

  assign f = sel_d[LABF_LAT-1] ? r_a[CBRT_STEPS-1] : lin_d[LIN_DLY-1];

endmodule

FILE: src/rgblab_lane.sv
// One color lane: sRGB table lookup, XYZ matrix with white normalization,
// companding and Lab assembly in Q24. Depends on rgblab_pkg, rgblab_cdiv, rgblab_labf.
module rgblab_lane (
  input  logic             clk,
  input  logic             en,
  input  logic [7:0]       red,
  input  logic [7:0]       green,
  input  logic [7:0]       blue,
  output rgblab_pkg::lab_t lab
);
  import rgblab_pkg::*;

  lin_t  lin_r, lin_g, lin_b;
  num_t  pxr, pxg, pxb, pyr, pyg, pyb, pzr, pzg, pzb;
  num_t  nx, ny, nz, qx, qy, qz;
  lin_t  fx, fy, fz;
  labv_t fx_s, fy_s, fz_s;

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r <= LIN_TABLE[red];
      lin_g <= LIN_TABLE[green];
      lin_b <= LIN_TABLE[blue];
      pxr   <= NUM_W'(lin_r) * COEF_XR;
      pxg   <= NUM_W'(lin_g) * COEF_XG;
      pxb   <= NUM_W'(lin_b) * COEF_XB;
      pyr   <= NUM_W'(lin_r) * COEF_YR;
      pyg   <= NUM_W'(lin_g) * COEF_YG;
      pyb   <= NUM_W'(lin_b) * COEF_YB;
      pzr   <= NUM_W'(lin_r) * COEF_ZR;
      pzg   <= NUM_W'(lin_g) * COEF_ZG;
      pzb   <= NUM_W'(lin_b) * COEF_ZB;
      nx    <= pxr + pxg + pxb + RND_X;
      ny    <= pyr + pyg + pyb + RND_Y;
      nz    <= pzr + pzg + pzb + RND_Z;
      lab.lightness   <= fy_s * LAB_C_L - L_OFS;
      lab.green_red   <= (fx_s - fy_s) * LAB_C_A;
      lab.blue_yellow <= (fy_s - fz_s) * LAB_C_B;
    end
  end

  rgblab_cdiv #(.NW(NUM_W), .DIVISOR(DIV_X)) u_div_x (.clk(clk), .en(en), .num(nx), .quo(qx));
  rgblab_cdiv #(.NW(NUM_W), .DIVISOR(DIV_Y)) u_div_y (.clk(clk), .en(en), .num(ny), .quo(qy));
  rgblab_cdiv #(.NW(NUM_W), .DIVISOR(DIV_Z)) u_div_z (.clk(clk), .en(en), .num(nz), .quo(qz));

  rgblab_labf u_f_x (.clk(clk), .en(en), .v(qx[LIN_W-1:0]), .f(fx));
  rgblab_labf u_f_y (.clk(clk), .en(en), .v(qy[LIN_W-1:0]), .f(fy));
  rgblab_labf u_f_z (.clk(clk), .en(en), .v(qz[LIN_W-1:0]), .f(fz));

  assign fx_s = labv_t'(fx);
  assign fy_s = labv_t'(fy);
  assign fz_s = labv_t'(fz);

endmodule

FILE: src/rgblab_merge.sv
// Merge stage: rounds and saturates both Lab triples and computes the CIE76
// distance with a pipelined square root. Depends on rgblab_pkg.
module rgblab_merge #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                              clk,
  input  logic                              en,
  input  rgblab_pkg::lab_t                  first,
  input  rgblab_pkg::lab_t                  second,
  output logic [rgblab_pkg::L_W-1:0]        first_lightness,
  output logic signed [rgblab_pkg::AB_W-1:0] first_green_red,
  output logic signed [rgblab_pkg::AB_W-1:0] first_blue_yellow,
  output logic [rgblab_pkg::L_W-1:0]        second_lightness,
  output logic signed [rgblab_pkg::AB_W-1:0] second_green_red,
  output logic signed [rgblab_pkg::AB_W-1:0] second_blue_yellow,
  output logic [rgblab_pkg::DIST_W-1:0]     colour_distance
);
  import rgblab_pkg::*;

  localparam int DIFF_W = LAB_W + 1;
  localparam int DQ_W   = 27;
  localparam int SUM_W  = 56;
  localparam int ROOT_W = SQRT_STEPS;
  localparam int SH     = Q_FRAC - FRACTION_BITS;
  localparam int DSH    = DIST_FRAC - FRACTION_BITS;
  localparam int OUT_DLY = MERGE_LAT - 1;
  localparam logic [LAB_W-1:0]  HALF  = LAB_W'(1) << (SH - 1);
  localparam logic [ROOT_W-1:0] DHALF = ROOT_W'((1 << DSH) >> 1);
  localparam logic [DIFF_W-1:0] DQ_HALF = DIFF_W'(128);

  typedef struct packed {
    logic [L_W-1:0]  l1;
    logic [AB_W-1:0] a1;
    logic [AB_W-1:0] b1;
    logic [L_W-1:0]  l2;
    logic [AB_W-1:0] a2;
    logic [AB_W-1:0] b2;
  } fields_t;

  labv_t                    vals [6];
  logic [LAB_W-1:0]         mag [6];
  logic [LAB_W-1:0]         rm [6];
  logic                     neg [6];
  logic signed [DIFF_W-1:0] diff [3];
  logic [DIFF_W-1:0]        dmag [3];
  logic [DIFF_W-1:0]        dsum [3];
  logic [DQ_W-1:0]          dq [3];
  logic [SUM_W-1:0]         sq [3];
  logic [SUM_W-1:0]         sum;
  logic [SUM_W-1:0]         n_a [SQRT_STEPS];
  logic [SUM_W-1:0]         res_a [SQRT_STEPS];
  logic [ROOT_W:0]          rsum;
  fields_t                  rnd;
  fields_t                  out_d [OUT_DLY];

  function automatic logic [L_W-1:0] clamp_l(logic n, logic [LAB_W-1:0] m);
    if (n) return '0;
    else if (m > LAB_W'(L_MAX)) return L_MAX;
    else return m[L_W-1:0];
  endfunction

  function automatic logic [AB_W-1:0] clamp_ab(logic n, logic [LAB_W-1:0] m);
    if (n) begin
      if (m > LAB_W'(AB_MIN)) return AB_MIN;
      else return -m[AB_W-1:0];
    end else if (m > LAB_W'(AB_MAX)) begin
      return AB_MAX;
    end else begin
      return m[AB_W-1:0];
    end
  endfunction

  assign vals[0] = first.lightness;
  assign vals[1] = first.green_red;
  assign vals[2] = first.blue_yellow;
  assign vals[3] = second.lightness;
  assign vals[4] = second.green_red;
  assign vals[5] = second.blue_yellow;

  always_comb begin
    for (int k = 0; k < 6; k++) rm[k] = (mag[k] + HALF) >> SH;
    rnd.l1 = clamp_l(neg[0], rm[0]);
    rnd.a1 = clamp_ab(neg[1], rm[1]);
    rnd.b1 = clamp_ab(neg[2], rm[2]);
    rnd.l2 = clamp_l(neg[3], rm[3]);
    rnd.a2 = clamp_ab(neg[4], rm[4]);
    rnd.b2 = clamp_ab(neg[5], rm[5]);
    for (int k = 0; k < 3; k++) dsum[k] = dmag[k] + DQ_HALF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        neg[k] <= vals[k] < 0;
        mag[k] <= (vals[k] < 0) ? LAB_W'(-vals[k]) : LAB_W'(vals[k]);
      end
      for (int k = 0; k < 3; k++) begin
        diff[k] <= DIFF_W'(vals[k+3]) - DIFF_W'(vals[k]);
        dmag[k] <= (diff[k] < 0) ? DIFF_W'(-diff[k]) : DIFF_W'(diff[k]);
        dq[k]   <= dsum[k][DQ_W+7:8];
        sq[k]   <= SUM_W'(dq[k]) * SUM_W'(dq[k]);
      end
      sum      <= sq[0] + sq[1] + sq[2];
      out_d[0] <= rnd;
      for (int k = 1; k < OUT_DLY; k++) out_d[k] <= out_d[k-1];
      colour_distance <= (rsum > (ROOT_W+1)'(DIST_MAX)) ? DIST_MAX : rsum[DIST_W-1:0];
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - i));
    logic [SUM_W-1:0] n_in, res_in, trial;
    logic [SUM_W:0]   dif;
    if (i == 0) begin : g_first
      assign n_in   = sum;
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = n_a[i-1];
      assign res_in = res_a[i-1];
    end
    assign trial = res_in + BIT;
    assign dif   = {1'b0, n_in} - {1'b0, trial};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!dif[SUM_W]) begin
          n_a[i]   <= dif[SUM_W-1:0];
          res_a[i] <= (res_in >> 1) + BIT;
        end else begin
          n_a[i]   <= n_in;
          res_a[i] <= res_in >> 1;
        end
      end
    end
  end

  assign rsum = ((ROOT_W+1)'(res_a[SQRT_STEPS-1][ROOT_W-1:0]) + (ROOT_W+1)'(DHALF)) >> DSH;

  assign first_lightness    = out_d[OUT_DLY-1].l1;
  assign first_green_red    = out_d[OUT_DLY-1].a1;
  assign first_blue_yellow  = out_d[OUT_DLY-1].b1;
  assign second_lightness   = out_d[OUT_DLY-1].l2;
  assign second_green_red   = out_d[OUT_DLY-1].a2;
  assign second_blue_yellow = out_d[OUT_DLY-1].b2;

endmodule

FILE: src/rgb_to_lab_color_difference.sv
// Top level: two sRGB colors in, both CIELAB triples and their CIE76 distance out.
// Depends on rgblab_pkg, rgblab_lane and rgblab_merge.
//
// Input channel (pair_valid / pair_stall) carries two 8-bit sRGB colors per
// transaction. Output channel (lab_valid / lab_stall) carries L*, a*, b* of
// each color and the distance, all in units of 2^-FRACTION_BITS, saturated
// to their field widths.
// One lane per color runs table lookup, XYZ matrix, constant division and
// the companding function; the merge stage rounds and takes the distance.
// Most of the pipeline lies in the 25-step cube root of each lane (two stages
// per step) and in the 28-step square root of the merge stage. Throughput is
// one transaction per cycle while the receiver does not stall a waiting result.
// When the receiver stalls a waiting result, the whole pipeline holds and
// pair_stall rises; it drops as soon as the result is taken.
// Reset clears only the valid bits of the pipeline; the data registers are not reset.
module rgb_to_lab_color_difference #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pair_valid,
  output logic                                pair_stall,
  input  logic [7:0]                          first_red,
  input  logic [7:0]                          first_green,
  input  logic [7:0]                          first_blue,
  input  logic [7:0]                          second_red,
  input  logic [7:0]                          second_green,
  input  logic [7:0]                          second_blue,
  output logic                                lab_valid,
  input  logic                                lab_stall,
  output logic [rgblab_pkg::L_W-1:0]          first_lightness,
  output logic signed [rgblab_pkg::AB_W-1:0]  first_green_red,
  output logic signed [rgblab_pkg::AB_W-1:0]  first_blue_yellow,
  output logic [rgblab_pkg::L_W-1:0]          second_lightness,
  output logic signed [rgblab_pkg::AB_W-1:0]  second_green_red,
  output logic signed [rgblab_pkg::AB_W-1:0]  second_blue_yellow,
  output logic [rgblab_pkg::DIST_W-1:0]       colour_distance
);
  import rgblab_pkg::*;

  logic [TOTAL_LAT-1:0] vld;
  logic                 en;
  lab_t                 lab_first, lab_second;

  assign lab_valid  = vld[TOTAL_LAT-1];
  assign en         = !(lab_valid && lab_stall);
  assign pair_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL_LAT-2:0], pair_valid};
    end
  end

  rgblab_lane u_lane_first (
    .clk   (clk),
    .en    (en),
    .red   (first_red),
    .green (first_green),
    .blue  (first_blue),
    .lab   (lab_first)
  );

  rgblab_lane u_lane_second (
    .clk   (clk),
    .en    (en),
    .red   (second_red),
    .green (second_green),
    .blue  (second_blue),
    .lab   (lab_second)
  );

  rgblab_merge #(.FRACTION_BITS(FRACTION_BITS)) u_merge (
    .clk                (clk),
    .en                 (en),
    .first              (lab_first),
    .second             (lab_second),
    .first_lightness    (first_lightness),
    .first_green_red    (first_green_red),
    .first_blue_yellow  (first_blue_yellow),
    .second_lightness   (second_lightness),
    .second_green_red   (second_green_red),
    .second_blue_yellow (second_blue_yellow),
    .colour_distance    (colour_distance)
  );

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    lab_valid && lab_stall |-> pair_stall)
    else $error("stalled result did not hold the input");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !lab_valid |-> !pair_stall)
    else $error("input stalled with no result waiting");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !lab_valid)
    else $error("result valid right after reset");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for rgb_to_lab_color_difference: streams sRGB color pairs,
// predicts both CIELAB triples and the CIE76 distance in fixed point, checks each result.
// Depends on rgblab_pkg and the RTL top level only.
module tb_top;
  import rgblab_pkg::*;

  localparam int FRAC = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam longint unsigned ONE_Q24 = 64'd1 << 24;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct {
    logic [L_W-1:0]           l1;
    logic signed [AB_W-1:0]   a1;
    logic signed [AB_W-1:0]   b1;
    logic [L_W-1:0]           l2;
    logic signed [AB_W-1:0]   a2;
    logic signed [AB_W-1:0]   b2;
    logic [DIST_W-1:0]        delta;
  } lab_pair_t;

  class lab_scoreboard;
    lab_pair_t expected_q[$];
    int errors;
    longint unsigned srgb_lut[256];

    function new();
      longint unsigned t, s, lo, hi, mid, p, lin30;
      errors = 0;
      for (int c = 0; c < 256; c++) begin
        if (longint'(c) * 100000 <= 255 * 4045) begin
          srgb_lut[c] = (longint'(c) * 64'd1677721600 + 64'd164730) / 64'd329460;
        end else begin
          t = (((64'd1000 * c + 64'd14025) << 30) + 64'd134512) / 64'd269025;
          s = (t * t + (ONE_Q30 >> 1)) >> 30;
          lo = 0;
          hi = ONE_Q30;
          while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            p = mid;
            for (int k = 0; k < 4; k++) p = (p * mid) >> 30;
            if (p <= s) lo = mid;
            else hi = mid - 1;
          end
          lin30 = (s * lo + (ONE_Q30 >> 1)) >> 30;
          srgb_lut[c] = (lin30 + 32) >> 6;
        end
      end
    endfunction

    function longint unsigned companding(longint unsigned v);
      longint unsigned lo, hi, mid;
      if (v * 1000000 > 8856 * ONE_Q24) begin
        lo = 0;
        hi = (ONE_Q24 << 1) - 1;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if ((((mid * mid) >> 24) * mid) >> 24 <= v) lo = mid;
          else hi = mid - 1;
        end
        return lo;
      end
      return (7787 * v + 500) / 1000 + ((4 * ONE_Q24) + 14) / 29;
    endfunction

    function longint round_to(longint v, int sh);
      longint unsigned half;
      half = (sh > 0) ? (64'd1 << (sh - 1)) : 0;
      if (v >= 0) return longint'((longint'(v) + half) >>> sh);
      return -longint'((longint'(-v) + half) >>> sh);
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void rgb_to_lab(input logic [7:0] r, g, b, output longint lab[3]);
      longint unsigned lr, lg, lb, x, y, z;
      longint fx, fy, fz;
      lr = srgb_lut[r];
      lg = srgb_lut[g];
      lb = srgb_lut[b];
      x = (41240 * lr + 35760 * lg + 18050 * lb + 47523) / 95047;
      y = (2126 * lr + 7152 * lg + 722 * lb + 5000) / 10000;
      z = (1930 * lr + 11920 * lg + 95050 * lb + 54441) / 108883;
      fx = companding(x);
      fy = companding(y);
      fz = companding(z);
      lab[0] = 116 * fy - longint'(16 * ONE_Q24);
      lab[1] = 500 * (fx - fy);
      lab[2] = 200 * (fy - fz);
    endfunction

    function void note_pair(input logic [7:0] r1, g1, b1, r2, g2, b2);
      longint lab1[3], lab2[3];
      longint d;
      longint unsigned sum, root, bitv, n;
      lab_pair_t e;
      rgb_to_lab(r1, g1, b1, lab1);
      rgb_to_lab(r2, g2, b2, lab2);
      e.l1 = L_W'(clip(round_to(lab1[0], 24 - FRAC), 0, 32767));
      e.a1 = AB_W'(clip(round_to(lab1[1], 24 - FRAC), -32768, 32767));
      e.b1 = AB_W'(clip(round_to(lab1[2], 24 - FRAC), -32768, 32767));
      e.l2 = L_W'(clip(round_to(lab2[0], 24 - FRAC), 0, 32767));
      e.a2 = AB_W'(clip(round_to(lab2[1], 24 - FRAC), -32768, 32767));
      e.b2 = AB_W'(clip(round_to(lab2[2], 24 - FRAC), -32768, 32767));
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        d = round_to(lab2[k] - lab1[k], 8);
        if (d < 0) d = -d;
        sum += longint'(d) * longint'(d);
      end
      n = sum;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      root = (root + (64'd1 << (16 - FRAC - 1))) >> (16 - FRAC);
      if (root > 131071) root = 131071;
      e.delta = DIST_W'(root);
      expected_q.push_back(e);
    endfunction

    task report(string field, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d", field, got, want);
      errors++;
    endtask

    task check_result(lab_pair_t got);
      lab_pair_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      e = expected_q.pop_front();
      if (got.l1 !== e.l1) report("first_lightness", got.l1, e.l1);
      if (got.a1 !== e.a1) report("first_green_red", got.a1, e.a1);
      if (got.b1 !== e.b1) report("first_blue_yellow", got.b1, e.b1);
      if (got.l2 !== e.l2) report("second_lightness", got.l2, e.l2);
      if (got.a2 !== e.a2) report("second_green_red", got.a2, e.a2);
      if (got.b2 !== e.b2) report("second_blue_yellow", got.b2, e.b2);
      if (got.delta !== e.delta) report("colour_distance", got.delta, e.delta);
    endtask
  endclass

  logic clk, rst;
  logic pair_valid, pair_stall, lab_valid, lab_stall;
  logic [7:0] first_red, first_green, first_blue, second_red, second_green, second_blue;
  logic [L_W-1:0] first_lightness, second_lightness;
  logic signed [AB_W-1:0] first_green_red, first_blue_yellow;
  logic signed [AB_W-1:0] second_green_red, second_blue_yellow;
  logic [DIST_W-1:0] colour_distance;

  lab_scoreboard sb = new();
  int pairs_taken = 0;
  int quiet_cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;

  rgb_to_lab_color_difference #(.FRACTION_BITS(FRAC)) DUT (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      lab_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      lab_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    lab_pair_t got;
    if (!rst) begin
      if ((pair_valid && !pair_stall) || (lab_valid && !lab_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (pair_valid && !pair_stall) begin
        sb.note_pair(first_red, first_green, first_blue, second_red, second_green, second_blue);
        pairs_taken <= pairs_taken + 1;
      end
      if (lab_valid && !lab_stall) begin
        got.l1 = first_lightness;
        got.a1 = first_green_red;
        got.b1 = first_blue_yellow;
        got.l2 = second_lightness;
        got.a2 = second_green_red;
        got.b2 = second_blue_yellow;
        got.delta = colour_distance;
        sb.check_result(got);
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_pair(input logic [7:0] r1, g1, b1, r2, g2, b2);
    int prev;
    if ($urandom_range(99) < send_idle) begin
      pair_valid <= 1'b0;
      @(negedge clk);
    end
    pair_valid <= 1'b1;
    first_red <= r1;
    first_green <= g1;
    first_blue <= b1;
    second_red <= r2;
    second_green <= g2;
    second_blue <= b2;
    prev = pairs_taken;
    do @(negedge clk); while (pairs_taken == prev);
  endtask

  task automatic drain();
    pair_valid <= 1'b0;
    @(negedge clk);
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_random(int count);
    logic [7:0] c[6];
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(9);
      for (int k = 0; k < 6; k++) c[k] = $urandom_range(255);
      if (mode == 0) begin
        for (int k = 0; k < 6; k++) c[k] = $urandom_range(24);
      end else if (mode == 1) begin
        for (int k = 0; k < 3; k++) c[k + 3] = c[k] ^ 8'($urandom_range(3));
      end
      send_pair(c[0], c[1], c[2], c[3], c[4], c[5]);
    end
  endtask

  initial begin
    rst = 1'b1;
    pair_valid = 1'b0;
    lab_stall = 1'b0;
    {first_red, first_green, first_blue} = '0;
    {second_red, second_green, second_blue} = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // extremes, primaries, the linear/gamma break at 10/11, dark linear Lab segment
    send_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    send_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    send_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0);
    send_pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0);
    send_pair(8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255);
    send_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255);
    send_pair(8'd10, 8'd10, 8'd10, 8'd11, 8'd11, 8'd11);
    send_pair(8'd10, 8'd11, 8'd10, 8'd11, 8'd10, 8'd11);
    send_pair(8'd1, 8'd1, 8'd1, 8'd2, 8'd2, 8'd2);
    send_pair(8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9);
    send_pair(8'd20, 8'd0, 8'd0, 8'd0, 8'd0, 8'd20);
    send_pair(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
    send_pair(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pair(8'd128, 8'd128, 8'd128, 8'd127, 8'd127, 8'd127);
    send_pair(8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85);
    send_pair(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255);
    send_pair(8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0);
    drain();

    send_idle = 22;
    recv_idle = 49;
    send_random(150);
    @(posedge clk);
    hold_left = 400;
    send_random(320);

    send_idle = 49;
    recv_idle = 22;
    send_random(230);
    drain();
    send_random(230);

    send_idle = 0;
    recv_idle = 0;
    send_random(470);

    drain();
    repeat (120) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
